/* design/kdht_pkg.sv */
// ---------------------------------------------------------------------------
// kdht_pkg: shared types and constants
// Hash constants, label tables, register indexes and the queue item type.
// ---------------------------------------------------------------------------
package kdht_pkg;

    localparam logic [63:0] FNV_OFFSET = 64'hcbf29ce484222325;
    localparam logic [63:0] FNV_PRIME  = 64'h00000100000001b3;
    localparam logic [63:0] SEED_TAG_A = 64'h9f8b7c6d5e4f3021;
    localparam logic [63:0] SEED_TAG_B = 64'h1023456789abcdef;
    localparam logic [63:0] SM_GAMMA   = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] SM_MUL1    = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] SM_MUL2    = 64'h94d049bb133111eb;

    // Register indexes on the configuration channel
    localparam logic [2:0] REG_KEY_LOW    = 3'd0;
    localparam logic [2:0] REG_KEY_HIGH   = 3'd1;
    localparam logic [2:0] REG_NONCE_LOW  = 3'd2;
    localparam logic [2:0] REG_NONCE_HIGH = 3'd3;
    localparam logic [2:0] REG_TAG_A      = 3'd4;
    localparam logic [2:0] REG_TAG_B      = 3'd5;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] cipher_byte;
        logic       is_last;
    } t_item;

    typedef struct packed {
        logic [63:0] key_low;
        logic [63:0] key_high;
        logic [63:0] nonce_low;
        logic [63:0] nonce_high;
        logic [63:0] expected_tag_a;
        logic [63:0] expected_tag_b;
    } t_cfg;

    // One FNV-1a 64 byte step; the prime is 2^40 + 0x1b3
    function automatic logic [63:0] fnv_absorb(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x * 64'h1b3);
    endfunction

    // Label bytes "auth-v1" / "auth-v2" (last byte picks the version)
    function automatic logic [7:0] label_auth(input logic [2:0] idx, input logic [7:0] ver);
        case (idx)
            3'd0:    return 8'h61;
            3'd1:    return 8'h75;
            3'd2:    return 8'h74;
            3'd3:    return 8'h68;
            3'd4:    return 8'h2d;
            3'd5:    return 8'h76;
            3'd6:    return ver;
            default: return 8'h00;
        endcase
    endfunction

endpackage

/* design/keystream_decrypt_with_hash_tag.sv */
// ---------------------------------------------------------------------------
// keystream_decrypt_with_hash_tag: keystream decryptor with two-word hash tag
// Decrypts one byte per request and checks the tag on the message end.
// ---------------------------------------------------------------------------
// Usage:
//   Write key, nonce and expected tags on the cfg channel (index 0..5) while
//   idle; the channel is always ready. Send cipher bytes on the s_axis
//   channel, tlast on the final byte. Each byte yields one result on m_axis:
//   tdata is the plain byte, tlast marks the end, tuser is the tag match
//   (valid only with tlast). Plaintext leaves before the tag is known, so
//   discard the message when tuser is 0 on its last result.
// Operation:
//   A byte passes through the engine in three steps (pop, absorb, emit). Every
//   eighth byte also draws a keystream word on the shared 32x32
//   multiplier (two 64-bit multiplies of three partial products each).
//   For the first byte of a message the engine first primes the hashes, one
//   key, nonce or label byte per cycle.
// Reset empties the queue and clears the engine state and the configuration
// registers. When the receiver stalls, the result register holds, the engine
// waits and the input queue fills, then deasserts tready.
// ---------------------------------------------------------------------------
module keystream_decrypt_with_hash_tag import kdht_pkg::*; #(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] cipher_byte
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] plain_byte
    output logic        o_m_axis_tlast,
    output logic        o_m_axis_tuser    // [0] tag_match
);
    t_cfg  r_cfg;
    t_item in_item, q_item;
    logic  q_avail, q_pop;

    assign o_cfg_ready = 1'b1;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_KEY_LOW:    r_cfg.key_low        <= i_cfg_data;
                REG_KEY_HIGH:   r_cfg.key_high       <= i_cfg_data;
                REG_NONCE_LOW:  r_cfg.nonce_low      <= i_cfg_data;
                REG_NONCE_HIGH: r_cfg.nonce_high     <= i_cfg_data;
                REG_TAG_A:      r_cfg.expected_tag_a <= i_cfg_data;
                REG_TAG_B:      r_cfg.expected_tag_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign in_item.cipher_byte = i_s_axis_tdata;
    assign in_item.is_last     = i_s_axis_tlast;

    kdht_front #(.DEPTH(QDEPTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_item  (in_item),
        .o_avail (q_avail),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    kdht_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_avail (q_avail),
        .i_item  (q_item),
        .o_pop   (q_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_plain (o_m_axis_tdata),
        .o_eom   (o_m_axis_tlast),
        .o_match (o_m_axis_tuser)
    );
endmodule

/* design/kdht_front.sv */
// ---------------------------------------------------------------------------
// kdht_front: input queue
// Accepts cipher bytes from the stream and holds them for the engine.
// ---------------------------------------------------------------------------
module kdht_front import kdht_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_avail,
    output t_item o_item,
    input  logic  i_pop
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_cnt;
    logic           push;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign push    = i_valid && o_ready;
    assign o_avail = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];

    // Store incoming bytes
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CW'(push) - CW'(i_pop);
        end
    end
endmodule

/* design/kdht_core.sv */
// ---------------------------------------------------------------------------
// kdht_core: decrypt engine
// Primes the hashes, absorbs bytes, draws splitmix words, drives results.
// ---------------------------------------------------------------------------
module kdht_core import kdht_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_avail,
    input  t_item      i_item,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_plain,
    output logic       o_eom,
    output logic       o_match
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PRIME  = 3'd1;
    localparam logic [2:0] S_ABSORB = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    logic [2:0]  r_state;
    logic [5:0]  r_cnt;
    logic [1:0]  r_k;
    logic        r_phase;
    logic        r_in_msg;
    logic [3:0]  r_slot;
    logic [63:0] r_ha, r_hb, r_ctr, r_word, r_z, r_acc;
    logic [7:0]  r_cb;
    logic        r_last;
    logic        r_ovalid;
    logic [7:0]  r_plain;
    logic        r_eom, r_match;

    logic [255:0] kn;
    logic [7:0]   kbyte, byte_a, byte_b, byte_s;
    logic [63:0]  n_ctr, mconst, acc_n;
    logic [31:0]  ma, mb;
    logic [63:0]  prod;
    logic         out_free;

    assign kn     = {i_cfg.nonce_high, i_cfg.nonce_low, i_cfg.key_high, i_cfg.key_low};
    assign kbyte  = kn[{r_cnt[4:0], 3'b000} +: 8];
    assign byte_a = r_cnt[5] ? label_auth(r_cnt[2:0], 8'h31) : kbyte;
    assign byte_b = r_cnt[5] ? label_auth(r_cnt[2:0], 8'h32) : kbyte;
    assign byte_s = r_cnt[5] ? (r_cnt[0] ? 8'h31 : 8'h76) : kbyte;

    assign n_ctr  = r_ctr + SM_GAMMA;
    assign mconst = r_phase ? SM_MUL2 : SM_MUL1;

    // One 32x32 multiplier, three partial products per 64-bit multiply
    always_comb begin
        case (r_k)
            2'd0:    begin ma = r_z[31:0];  mb = mconst[31:0];  end
            2'd1:    begin ma = r_z[31:0];  mb = mconst[63:32]; end
            default: begin ma = r_z[63:32]; mb = mconst[31:0];  end
        endcase
        prod  = {32'd0, ma} * {32'd0, mb};
        acc_n = (r_k == 2'd0) ? prod : r_acc + {prod[31:0], 32'd0};
    end

    assign out_free = !r_ovalid || i_ready;
    assign o_pop    = (r_state == S_IDLE) && i_avail;
    assign o_valid  = r_ovalid;
    assign o_plain  = r_plain;
    assign o_eom    = r_eom;
    assign o_match  = r_match;

    // Latch the popped byte
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cb   <= i_item.cipher_byte;
            r_last <= i_item.is_last;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_k      <= '0;
            r_phase  <= 1'b0;
            r_in_msg <= 1'b0;
            r_slot   <= 4'd8;
            r_ovalid <= 1'b0;
            r_ha     <= '0;
            r_hb     <= '0;
            r_ctr    <= '0;
            r_word   <= '0;
        end else begin
            // drop the result once taken, unless a new one is loaded now
            if (r_ovalid && i_ready && (r_state != S_EMIT)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_avail) begin
                        if (!r_in_msg) begin
                            r_ha    <= SEED_TAG_A;
                            r_hb    <= SEED_TAG_B;
                            r_ctr   <= FNV_OFFSET;
                            r_cnt   <= '0;
                            r_state <= S_PRIME;
                        end else begin
                            r_state <= S_ABSORB;
                        end
                    end
                end
                S_PRIME: begin
                    // key and nonce bytes, then the labels
                    r_ha <= fnv_absorb(r_ha, byte_a);
                    r_hb <= fnv_absorb(r_hb, byte_b);
                    if (r_cnt < 6'd34) begin
                        r_ctr <= fnv_absorb(r_ctr, byte_s);
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 6'd38) begin
                        r_slot   <= 4'd8;
                        r_in_msg <= 1'b1;
                        r_state  <= S_ABSORB;
                    end
                end
                S_ABSORB: begin
                    r_ha <= fnv_absorb(r_ha, r_cb);
                    r_hb <= fnv_absorb(r_hb, r_cb);
                    if (r_slot[3]) begin
                        r_ctr   <= n_ctr;
                        r_z     <= n_ctr ^ (n_ctr >> 30);
                        r_k     <= '0;
                        r_phase <= 1'b0;
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_MUL: begin
                    r_acc <= acc_n;
                    r_k   <= (r_k == 2'd2) ? 2'd0 : r_k + 1'b1;
                    if (r_k == 2'd2) begin
                        if (!r_phase) begin
                            r_z     <= acc_n ^ (acc_n >> 27);
                            r_phase <= 1'b1;
                        end else begin
                            r_word  <= acc_n ^ (acc_n >> 31);
                            r_slot  <= '0;
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_plain  <= r_cb ^ r_word[{r_slot[2:0], 3'b000} +: 8];
                        r_eom    <= r_last;
                        r_match  <= r_last && (r_ha == i_cfg.expected_tag_a)
                                           && (r_hb == i_cfg.expected_tag_b);
                        r_slot   <= r_slot + 1'b1;
                        if (r_last) begin
                            r_in_msg <= 1'b0;
                        end
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= 4'd8)
        else $error("byte slot out of range");
    a_match_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_match |-> r_eom)
        else $error("tag match outside message end");
    a_emit_word_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> !r_slot[3])
        else $error("emit without a keystream word");
    a_prime_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PRIME |-> !r_in_msg)
        else $error("priming inside a message");
endmodule
